// File: design/bpg_pkg.sv
// ----------------------------------------------------------------------------
// bpg_pkg: shared types and constants for the button/pot gesture qualifier
// Item formats, operation codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package bpg_pkg;

    // Widths of the item fields and registers
    localparam int POT_RAW_W   = 10;
    localparam int POT_W       = 8;
    localparam int TIME_W      = 32;
    localparam int LIMIT_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Register reset values
    localparam logic [POT_W-1:0]   MOVE_THRESHOLD_RST = 8'd16;
    localparam logic [LIMIT_W-1:0] CLICK_LIMIT_RST    = 16'd1000;
    localparam logic [LIMIT_W-1:0] LONG_PRESS_RST     = 16'd2000;

    // Item operation codes
    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_REARM  = 1'b1
    } bpg_op_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MOVE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLICK_LIMIT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS     = 2'd2;

    // Input item
    typedef struct packed
    {
        bpg_op_t               operation;
        logic                  button_pressed;
        logic [POT_RAW_W-1:0]  pot_sample;
        logic [TIME_W-1:0]     now_ms;
    } bpg_in_t;

    // Result item
    typedef struct packed
    {
        logic              click;
        logic              long_press;
        logic              pot_new;
        logic              pot_new_held;
        logic [POT_W-1:0]  pot_value;
    } bpg_out_t;

endpackage

// File: design/button_pot_gesture_qualifier.sv
// ----------------------------------------------------------------------------
// button_pot_gesture_qualifier
// Turns polled button and pot samples into click, long press and pot-change
// flags, one result item per input item.
// ----------------------------------------------------------------------------
// Each accepted item produces exactly one result item, loaded into the result
// register as it is accepted. The block takes one item every cycle while its
// results are taken: in_ready is high whenever the result register is empty
// or its item is taken in the same cycle, so a steady stream runs at one item
// per clock. All gesture state is updated in the cycle the item is accepted,
// through one 8-bit distance compare and one 32-bit elapsed-time subtract with
// two compares against the 16-bit limits. Configuration writes take effect at
// the next edge and are meant to be made while no item is in flight.
// ----------------------------------------------------------------------------
module button_pot_gesture_qualifier
    import bpg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  bpg_in_t                in_item,

    output logic                   out_valid,
    input  logic                   out_ready,
    output bpg_out_t               out_item
);

    // Configuration registers
    logic [POT_W-1:0]   move_threshold_reg;
    logic [LIMIT_W-1:0] click_limit_reg;
    logic [LIMIT_W-1:0] long_press_reg;

    // Gesture state
    logic               btn_now_reg,       btn_now_next;
    logic               pot_moving_reg,    pot_moving_next;
    logic [POT_W-1:0]   pot_accepted_reg,  pot_accepted_next;
    logic [POT_W-1:0]   pot_reference_reg, pot_reference_next;
    logic [POT_W-1:0]   pot_latest_reg,    pot_latest_next;
    logic [TIME_W-1:0]  press_start_reg,   press_start_next;
    logic               turned_held_reg,   turned_held_next;
    logic               long_reported_reg, long_reported_next;

    // Result register
    logic               out_valid_reg;
    bpg_out_t           out_item_reg;
    bpg_out_t           result;

    // Step intermediates
    logic               accept;
    logic               btn;
    logic [POT_W-1:0]   pot_new_val;
    logic [POT_W-1:0]   pot_dist;
    logic               moving_pre;
    logic               rise;
    logic               btn_edge;
    logic               turned_pre;
    logic               reported_pre;
    logic [TIME_W-1:0]  start_pre;
    logic [TIME_W-1:0]  elapsed;
    logic               lp_fire;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    // Compute one step of the gesture logic for the item at the port
    always_comb
    begin
        btn          = in_item.button_pressed;
        pot_new_val  = in_item.pot_sample[POT_RAW_W-1 -: POT_W];
        pot_dist     = (pot_new_val >= pot_reference_reg) ?
                       (pot_new_val - pot_reference_reg) :
                       (pot_reference_reg - pot_new_val);
        moving_pre   = pot_moving_reg || (pot_dist > move_threshold_reg);
        rise         = !btn_now_reg && btn;
        btn_edge     = btn_now_reg != btn;
        turned_pre   = rise ? 1'b0 : turned_held_reg;
        reported_pre = rise ? 1'b0 : long_reported_reg;
        start_pre    = rise ? in_item.now_ms : press_start_reg;
        elapsed      = in_item.now_ms - start_pre;
        lp_fire      = !reported_pre && btn && !turned_pre &&
                       (elapsed > {{(TIME_W-LIMIT_W){1'b0}}, long_press_reg});

        // Default: hold state, flags low
        btn_now_next       = btn_now_reg;
        pot_moving_next    = pot_moving_reg;
        pot_accepted_next  = pot_accepted_reg;
        pot_reference_next = pot_reference_reg;
        pot_latest_next    = pot_latest_reg;
        press_start_next   = press_start_reg;
        turned_held_next   = turned_held_reg;
        long_reported_next = long_reported_reg;
        result             = '0;

        unique case (in_item.operation)
            OP_REARM:
            begin
                pot_moving_next    = 1'b0;
                pot_reference_next = pot_latest_reg;
            end
            OP_SAMPLE:
            begin
                btn_now_next       = btn;
                pot_latest_next    = pot_new_val;
                pot_accepted_next  = moving_pre ? pot_new_val : pot_accepted_reg;
                pot_moving_next    = btn_edge ? 1'b0 : moving_pre;
                pot_reference_next = btn_edge ? pot_new_val : pot_reference_reg;
                press_start_next   = start_pre;
                long_reported_next = reported_pre || lp_fire;

                result.click        = btn_now_reg && !btn && !turned_pre &&
                                      (elapsed < {{(TIME_W-LIMIT_W){1'b0}},
                                                  click_limit_reg});
                result.long_press   = lp_fire;
                result.pot_new      = !btn && pot_moving_next;
                result.pot_new_held = btn && pot_moving_next;
                turned_held_next    = turned_pre || result.pot_new_held;
            end
            default:
            begin
                result = '0;
            end
        endcase

        result.pot_value = pot_accepted_next;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_threshold_reg <= MOVE_THRESHOLD_RST;
            click_limit_reg    <= CLICK_LIMIT_RST;
            long_press_reg     <= LONG_PRESS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MOVE_THRESHOLD: move_threshold_reg <= cfg_data[POT_W-1:0];
                REG_CLICK_LIMIT:    click_limit_reg    <= cfg_data[LIMIT_W-1:0];
                REG_LONG_PRESS:     long_press_reg     <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Advance gesture state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btn_now_reg       <= 1'b0;
            pot_moving_reg    <= 1'b0;
            pot_accepted_reg  <= '0;
            pot_reference_reg <= '0;
            pot_latest_reg    <= '0;
            press_start_reg   <= '0;
            turned_held_reg   <= 1'b0;
            long_reported_reg <= 1'b0;
        end
        else if (accept)
        begin
            btn_now_reg       <= btn_now_next;
            pot_moving_reg    <= pot_moving_next;
            pot_accepted_reg  <= pot_accepted_next;
            pot_reference_reg <= pot_reference_next;
            pot_latest_reg    <= pot_latest_next;
            press_start_reg   <= press_start_next;
            turned_held_reg   <= turned_held_next;
            long_reported_reg <= long_reported_next;
        end
    end

    // Load the result register; drop valid once the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A result never reports a click and a long press together
    a_click_vs_long: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.click && out_item.long_press))
        else $error("click and long press in one result item");

    // Pot change is reported for one button level only
    a_pot_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.pot_new && out_item.pot_new_held))
        else $error("both pot change flags set");

    // A rearm item gives a result with all flags clear and the pot idle
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.operation == OP_REARM) |=>
        (out_valid && !out_item.click && !out_item.long_press &&
         !out_item.pot_new && !out_item.pot_new_held && !pot_moving_reg))
        else $error("rearm item gave flags or left pot moving");

    // A long press pulse marks the press as reported
    a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.long_press) |=> long_reported_reg)
        else $error("long press reported without marking the press");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the button/pot gesture qualifier
// Drives sample and rearm items over valid/ready, predicts every result item
// from a behavioral copy of the gesture state, and compares field by field.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import bpg_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    bpg_in_t                in_item = '0;

    logic                   out_valid;
    logic                   out_ready = 1'b0;
    bpg_out_t               out_item;

    button_pot_gesture_qualifier u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Clock: period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies used by the predictor
    logic [POT_W-1:0]   thr_cfg   = MOVE_THRESHOLD_RST;
    logic [LIMIT_W-1:0] click_cfg = CLICK_LIMIT_RST;
    logic [LIMIT_W-1:0] long_cfg  = LONG_PRESS_RST;

    // Predicted gesture state, all zero after reset
    logic               btn_cur      = 1'b0;
    logic               btn_last     = 1'b0;
    logic               pot_tracking = 1'b0;
    logic [POT_W-1:0]   pot_shown    = '0;
    logic [POT_W-1:0]   pot_anchor   = '0;
    logic [POT_W-1:0]   pot_recent   = '0;
    logic [TIME_W-1:0]  press_t0     = '0;
    logic [TIME_W-1:0]  sample_t     = '0;
    logic               held_turned  = 1'b0;
    logic               long_fired   = 1'b0;

    bpg_in_t  pending_samples[$];
    bpg_out_t expected_gestures[$];

    int  mismatch_count = 0;
    int  items_queued = 0;
    bit  calm = 1'b0;
    bit  in_took = 1'b0;
    int  tx_gap_left = 0;
    int  rx_gap_left = 0;
    int  rx_hold_left = 0;
    int  rx_long_reqs = 0;
    int  rx_long_seen = 0;

    // Generator state for well-formed gesture sequences
    logic [TIME_W-1:0] gen_t = '0;
    int                gen_pot = 0;

    // Advance the predicted state by one item and return its result
    function automatic bpg_out_t predict_gesture(bpg_in_t it);
        bpg_out_t          r;
        logic [POT_W-1:0]  pot_dist;
        logic [TIME_W-1:0] held_ms;
        r = '0;
        if (it.operation == OP_REARM)
        begin
            pot_tracking = 1'b0;
            pot_anchor   = pot_recent;
        end
        else
        begin
            sample_t   = it.now_ms;
            btn_last   = btn_cur;
            btn_cur    = it.button_pressed;
            pot_recent = it.pot_sample[POT_RAW_W-1:POT_RAW_W-POT_W];
            if (!pot_tracking)
            begin
                pot_dist = (pot_recent >= pot_anchor) ? pot_recent - pot_anchor
                                                      : pot_anchor - pot_recent;
                if (pot_dist > thr_cfg)
                    pot_tracking = 1'b1;
            end
            if (pot_tracking)
                pot_shown = pot_recent;
            // Rising edge starts a new press
            if (!btn_last && btn_cur)
            begin
                press_t0    = sample_t;
                held_turned = 1'b0;
                long_fired  = 1'b0;
            end
            // Any edge re-latches the pot reference
            if (btn_last != btn_cur)
            begin
                pot_tracking = 1'b0;
                pot_anchor   = pot_recent;
            end
            held_ms = sample_t - press_t0;
            r.click = btn_last && !btn_cur && !held_turned
                      && (held_ms < {16'd0, click_cfg});
            if (!long_fired && btn_cur && !held_turned && (held_ms > {16'd0, long_cfg}))
            begin
                long_fired   = 1'b1;
                r.long_press = 1'b1;
            end
            r.pot_new      = !btn_cur && pot_tracking;
            r.pot_new_held = btn_cur && pot_tracking;
            if (r.pot_new_held)
                held_turned = 1'b1;
        end
        r.pot_value = pot_shown;
        return r;
    endfunction

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Driver: offer pending items at the falling edge, with random gaps
    always @(negedge clk)
    begin
        logic    v;
        bpg_in_t it;
        v  = in_valid;
        it = in_item;
        if (!rst_n)
            v = 1'b0;
        else if (in_valid && !in_took)
            v = 1'b1;
        else if (tx_gap_left > 0)
        begin
            v = 1'b0;
            tx_gap_left--;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            v = 1'b0;
            tx_gap_left = $urandom_range(0, 14);
        end
        else if (pending_samples.size() > 0)
        begin
            v  = 1'b1;
            it = pending_samples.pop_front();
        end
        else
            v = 1'b0;
        in_valid <= v;
        in_item  <= it;
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    always @(negedge clk)
    begin
        logic rdy;
        if (rx_long_seen != rx_long_reqs)
        begin
            rx_long_seen++;
            rx_hold_left = 400;
        end
        if (!rst_n)
            rdy = 1'b0;
        else if (rx_hold_left > 0)
        begin
            rdy = 1'b0;
            rx_hold_left--;
        end
        else if (rx_gap_left > 0)
        begin
            rdy = 1'b0;
            rx_gap_left--;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            rdy = 1'b0;
            rx_gap_left = $urandom_range(0, 14);
        end
        else
            rdy = 1'b1;
        out_ready <= rdy;
    end

    // Monitor: check results first, then record newly accepted items
    always @(posedge clk)
    begin
        bpg_out_t want;
        if (!rst_n)
            in_took <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_gestures.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
                end
                else
                begin
                    want = expected_gestures.pop_front();
                    report_field("click", want.click, out_item.click);
                    report_field("long_press", want.long_press, out_item.long_press);
                    report_field("pot_new", want.pot_new, out_item.pot_new);
                    report_field("pot_new_held", want.pot_new_held, out_item.pot_new_held);
                    report_field("pot_value", want.pot_value, out_item.pot_value);
                end
            end
            if (in_valid && in_ready)
                expected_gestures.push_back(predict_gesture(in_item));
            in_took <= in_valid && in_ready;
        end
    end

    task automatic push_item(logic op, logic btn, int pot, logic [TIME_W-1:0] t);
        bpg_in_t it;
        it.operation      = bpg_op_t'(op);
        it.button_pressed = btn;
        it.pot_sample     = pot[POT_RAW_W-1:0];
        it.now_ms         = t;
        pending_samples.push_back(it);
        items_queued++;
    endtask

    task automatic push_noise();
        push_item($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1023), $urandom());
    endtask

    // Move the pot: a jump anywhere, or a small jitter around the last value
    task automatic step_pot(bit big);
        if (big)
            gen_pot = $urandom_range(0, 1023);
        else
        begin
            gen_pot = gen_pot + int'($urandom_range(0, 16)) - 8;
            if (gen_pot < 0)
                gen_pot = 0;
            if (gen_pot > 1023)
                gen_pot = 1023;
        end
    endtask

    // Queue one press/release gesture, durations near the limits or random, or a noise item
    task automatic push_gesture();
        int                pre_n;
        int                held_n;
        int                j;
        longint            dur;
        bit                turn;
        logic [TIME_W-1:0] start_t;
        if ($urandom_range(0, 9) == 0)
        begin
            push_noise();
            return;
        end
        if ($urandom_range(0, 15) == 0)
            gen_t = $urandom();
        else if ($urandom_range(0, 15) == 0)
            gen_t = 32'hFFFF_FFFF - $urandom_range(0, 5000);
        // Released samples
        pre_n = $urandom_range(0, 3);
        repeat (pre_n)
        begin
            gen_t = gen_t + $urandom_range(1, 400);
            step_pot($urandom_range(0, 2) == 0);
            push_item(OP_SAMPLE, 1'b0, gen_pot, gen_t);
        end
        if ($urandom_range(0, 7) == 0)
            push_item(OP_REARM, $urandom_range(0, 1), $urandom_range(0, 1023), $urandom());
        // Pick the press length
        case ($urandom_range(0, 4))
            0:       dur = $urandom_range(0, click_cfg);
            1:       dur = longint'(click_cfg) + int'($urandom_range(0, 2)) - 1;
            2:       dur = longint'(long_cfg) + int'($urandom_range(0, 3)) - 1;
            3:       dur = $urandom_range(0, 70000);
            default: dur = longint'($urandom());
        endcase
        if (dur < 0)
            dur = 0;
        held_n  = $urandom_range(1, 4);
        turn    = ($urandom_range(0, 2) == 0);
        start_t = gen_t + $urandom_range(1, 200);
        step_pot(1'b0);
        push_item(OP_SAMPLE, 1'b1, gen_pot, start_t);
        for (j = 1; j <= held_n; j++)
        begin
            step_pot(turn && ($urandom_range(0, 1) == 0));
            if ($urandom_range(0, 9) == 0)
                push_item(OP_REARM, $urandom_range(0, 1), $urandom_range(0, 1023), $urandom());
            push_item(OP_SAMPLE, 1'b1, gen_pot, start_t + 32'(dur * j / held_n));
        end
        gen_t = start_t + 32'(dur);
        step_pot(1'b0);
        push_item(OP_SAMPLE, 1'b0, gen_pot, gen_t);
    endtask

    // Hold until nothing is queued, offered or outstanding, then settle
    task automatic wait_idle();
        while (pending_samples.size() != 0 || in_valid || expected_gestures.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_regs(logic [7:0] thr, logic [15:0] clk_lim, logic [15:0] long_lim);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MOVE_THRESHOLD;
        cfg_data  <= {8'd0, thr};
        @(negedge clk);
        cfg_index <= REG_CLICK_LIMIT;
        cfg_data  <= clk_lim;
        @(negedge clk);
        cfg_index <= REG_LONG_PRESS;
        cfg_data  <= long_lim;
        @(negedge clk);
        cfg_write <= 1'b0;
        thr_cfg   = thr;
        click_cfg = clk_lim;
        long_cfg  = long_lim;
    endtask

    task automatic fill_random(int count);
        int target;
        target = items_queued + count;
        while (items_queued < target)
            push_gesture();
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed items at reset settings
        push_item(OP_SAMPLE, 1'b0, 0, 32'd0);
        push_item(OP_SAMPLE, 1'b0, 1023, 32'd10);
        push_item(OP_REARM, 1'b1, 517, 32'h5A5A_A5A5);
        push_item(OP_SAMPLE, 1'b0, 1020, 32'd20);
        // Short click
        push_item(OP_SAMPLE, 1'b1, 1023, 32'd100);
        push_item(OP_SAMPLE, 1'b0, 1023, 32'd500);
        // Long press, reported once, no click on release
        push_item(OP_SAMPLE, 1'b1, 1023, 32'd1000);
        push_item(OP_SAMPLE, 1'b1, 1022, 32'd2500);
        push_item(OP_SAMPLE, 1'b1, 1021, 32'd3001);
        push_item(OP_SAMPLE, 1'b1, 1023, 32'd4000);
        push_item(OP_SAMPLE, 1'b0, 1023, 32'd4100);
        // Pot turned while held suppresses both gestures
        push_item(OP_SAMPLE, 1'b1, 512, 32'd5000);
        push_item(OP_SAMPLE, 1'b1, 0, 32'd5100);
        push_item(OP_SAMPLE, 1'b1, 3, 32'd8000);
        push_item(OP_SAMPLE, 1'b0, 2, 32'd8100);
        // Timestamp wrap inside a click
        push_item(OP_SAMPLE, 1'b1, 2, 32'hFFFF_FF00);
        push_item(OP_SAMPLE, 1'b0, 1, 32'h0000_0100);
        // Timestamp going backwards reads as a very long press
        push_item(OP_SAMPLE, 1'b1, 700, 32'd1000);
        push_item(OP_SAMPLE, 1'b1, 701, 32'd500);
        push_item(OP_SAMPLE, 1'b0, 702, 32'd600);
        // Rearm ignores its other fields
        push_item(OP_REARM, 1'b1, 1023, 32'hFFFF_FFFF);
        push_item(OP_SAMPLE, 1'b0, 3, 32'hFFFF_FFFF);
        push_item(OP_SAMPLE, 1'b0, 1023, 32'hAAAA_5555);
        wait_idle();

        fill_random(260);
        wait_idle();

        // Lowest settings
        write_regs(8'd0, 16'd0, 16'd0);
        fill_random(260);
        wait_idle();

        // Highest settings
        write_regs(8'd255, 16'hFFFF, 16'hFFFF);
        fill_random(260);
        wait_idle();

        // Small limits; the receiver holds off so the block backs up
        write_regs(8'd4, 16'd300, 16'd600);
        fill_random(280);
        rx_long_reqs++;
        wait_idle();

        write_regs(8'($urandom_range(0, 255)), 16'($urandom_range(0, 5000)),
                   16'($urandom_range(0, 8000)));
        fill_random(300);
        wait_idle();

        write_regs(MOVE_THRESHOLD_RST, CLICK_LIMIT_RST, LONG_PRESS_RST);
        fill_random(300);
        wait_idle();

        // Final stretch without random gaps or stalls
        write_regs(8'($urandom_range(0, 255)), 16'($urandom()), 16'($urandom()));
        calm = 1'b1;
        fill_random(300);
        wait_idle();
        repeat (5) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
